### rtl/core/der_dsa_signature_to_raw_top_macros.svh
`ifndef DER_DSA_SIGNATURE_TO_RAW_TOP_MACROS_SVH
`define DER_DSA_SIGNATURE_TO_RAW_TOP_MACROS_SVH

// same-cycle implication
`define DSARAW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsaraw check failed");

// next-cycle implication
`define DSARAW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsaraw check failed");

`endif

### rtl/core/dsaraw_pkg.sv
package dsaraw_pkg;

   localparam int MAX_INT_BYTES = 32;
   localparam int BUF_DEPTH     = 2 * MAX_INT_BYTES;
   localparam int SIZE_W        = $clog2(MAX_INT_BYTES) + 1;
   localparam int IDX_W         = $clog2(BUF_DEPTH);
   localparam int COUNT_W       = $clog2(BUF_DEPTH) + 1;
   localparam int LEFT_W        = 7;

   localparam logic [7:0] TAG_SEQUENCE  = 8'h30;
   localparam logic [7:0] TAG_INTEGER   = 8'h02;
   localparam int         LONG_FORM_BIT = 7;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_TRUNCATED = 3'd1,
      STATUS_SEQ_TAG   = 3'd2,
      STATUS_INT_TAG   = 3'd3,
      STATUS_LONG_LEN  = 3'd4,
      STATUS_TOO_LONG  = 3'd5,
      STATUS_TRAILING  = 3'd6
   } status_type;

   typedef enum logic [6:0] {
      PHASE_SEQ_TAG = 7'b0000001,
      PHASE_SEQ_LEN = 7'b0000010,
      PHASE_INT_TAG = 7'b0000100,
      PHASE_INT_LEN = 7'b0001000,
      PHASE_INT_VAL = 7'b0010000,
      PHASE_DONE    = 7'b0100000,
      PHASE_ERR     = 7'b1000000
   } phase_type;

   typedef logic [BUF_DEPTH-1:0][7:0] raw_type;

   typedef struct packed {
      raw_type              raw;
      logic [COUNT_W-1:0]   count;
      status_type           status;
   } emit_load_type;

   // field width clamped to 1..MAX_INT_BYTES
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] r;
      r = s;
      if (s == '0) r = SIZE_W'(1);
      else if (int'(s) > MAX_INT_BYTES) r = SIZE_W'(MAX_INT_BYTES);
      return r;
   endfunction

endpackage

### rtl/core/dsaraw_if.sv
interface dsaraw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface dsaraw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic [2:0] status;

   modport source (output valid, output out_byte, output out_last, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input status,
                   output ready);
endinterface

### rtl/core/dsaraw_parse.sv
module dsaraw_parse (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [dsaraw_pkg::SIZE_W-1:0]         int_size,
   input  logic                                  take,
   input  logic [7:0]                            in_byte,
   input  logic                                  in_last,
   output dsaraw_pkg::emit_load_type             load_data
);

   dsaraw_pkg::phase_type                phase_ff, phase_in;
   logic                                 second_ff, second_in;
   logic [dsaraw_pkg::LEFT_W-1:0]        left_ff, left_in;
   logic                                 skip_ff, skip_in;
   dsaraw_pkg::status_type               err_ff, err_in;
   logic                                 tag_bad_ff, tag_bad_in;
   logic                                 oversize_ff, oversize_in;
   dsaraw_pkg::raw_type                  raw_ff, raw_in;

   logic [dsaraw_pkg::SIZE_W-1:0]        size;
   logic [dsaraw_pkg::IDX_W-1:0]         base;
   logic [dsaraw_pkg::IDX_W:0]           hi_wide;
   logic [dsaraw_pkg::IDX_W-1:0]         hi;
   logic                                 nonzero;
   logic                                 shift_en;
   logic                                 end_int;
   dsaraw_pkg::status_type               final_status;

   assign size    = dsaraw_pkg::eff_size(int_size);
   assign base    = second_ff ? dsaraw_pkg::IDX_W'(size) : '0;
   assign hi_wide = (dsaraw_pkg::IDX_W+1)'(base) + (dsaraw_pkg::IDX_W+1)'(size)
                    - (dsaraw_pkg::IDX_W+1)'(1);
   assign hi      = hi_wide[dsaraw_pkg::IDX_W-1:0];
   assign nonzero = !(skip_ff && (in_byte == 8'd0));

   always_comb begin
      phase_in    = phase_ff;
      second_in   = second_ff;
      left_in     = left_ff;
      skip_in     = skip_ff;
      err_in      = err_ff;
      tag_bad_in  = tag_bad_ff;
      oversize_in = oversize_ff;
      shift_en    = 1'b0;
      end_int     = 1'b0;
      unique case (phase_ff)
         dsaraw_pkg::PHASE_SEQ_TAG: begin
            tag_bad_in = (in_byte != dsaraw_pkg::TAG_SEQUENCE);
            phase_in   = dsaraw_pkg::PHASE_SEQ_LEN;
         end
         dsaraw_pkg::PHASE_SEQ_LEN: begin
            if (tag_bad_ff) begin
               err_in   = dsaraw_pkg::STATUS_SEQ_TAG;
               phase_in = dsaraw_pkg::PHASE_ERR;
            end else if (in_byte[dsaraw_pkg::LONG_FORM_BIT]) begin
               err_in   = dsaraw_pkg::STATUS_LONG_LEN;
               phase_in = dsaraw_pkg::PHASE_ERR;
            end else begin
               phase_in = dsaraw_pkg::PHASE_INT_TAG;
            end
         end
         dsaraw_pkg::PHASE_INT_TAG: begin
            tag_bad_in = (in_byte != dsaraw_pkg::TAG_INTEGER);
            phase_in   = dsaraw_pkg::PHASE_INT_LEN;
         end
         dsaraw_pkg::PHASE_INT_LEN: begin
            if (tag_bad_ff) begin
               err_in   = dsaraw_pkg::STATUS_INT_TAG;
               phase_in = dsaraw_pkg::PHASE_ERR;
            end else if (in_byte[dsaraw_pkg::LONG_FORM_BIT]) begin
               err_in   = dsaraw_pkg::STATUS_LONG_LEN;
               phase_in = dsaraw_pkg::PHASE_ERR;
            end else begin
               left_in     = in_byte[dsaraw_pkg::LEFT_W-1:0];
               skip_in     = 1'b1;
               oversize_in = 1'b0;
               if (in_byte[dsaraw_pkg::LEFT_W-1:0] == '0) end_int = 1'b1;
               else phase_in = dsaraw_pkg::PHASE_INT_VAL;
            end
         end
         dsaraw_pkg::PHASE_INT_VAL: begin
            if (nonzero) begin
               if (skip_ff) begin
                  skip_in = 1'b0;
                  if (left_ff > dsaraw_pkg::LEFT_W'(size)) oversize_in = 1'b1;
               end
               shift_en = !oversize_in;
            end
            left_in = left_ff - dsaraw_pkg::LEFT_W'(1);
            if (left_in == '0) end_int = 1'b1;
         end
         dsaraw_pkg::PHASE_DONE: begin
            err_in   = dsaraw_pkg::STATUS_TRAILING;
            phase_in = dsaraw_pkg::PHASE_ERR;
         end
         dsaraw_pkg::PHASE_ERR: begin
         end
         default: begin
         end
      endcase
      if (end_int) begin
         if (oversize_in) begin
            err_in   = dsaraw_pkg::STATUS_TOO_LONG;
            phase_in = dsaraw_pkg::PHASE_ERR;
         end else if (second_ff) begin
            phase_in = dsaraw_pkg::PHASE_DONE;
         end else begin
            second_in = 1'b1;
            phase_in  = dsaraw_pkg::PHASE_INT_TAG;
         end
      end
   end

   // field shifts down by one byte toward its base slot, new byte enters at its top slot (hi)
   always_comb begin
      raw_in = raw_ff;
      for (int j = 0; j < dsaraw_pkg::BUF_DEPTH; j++) begin
         if (shift_en && (dsaraw_pkg::IDX_W'(j) >= base) && (dsaraw_pkg::IDX_W'(j) < hi)) begin
            raw_in[j] = raw_ff[(j + 1) % dsaraw_pkg::BUF_DEPTH];
         end else if (shift_en && (dsaraw_pkg::IDX_W'(j) == hi)) begin
            raw_in[j] = in_byte;
         end
      end
   end

   always_comb begin
      final_status = err_in;
      if ((err_in == dsaraw_pkg::STATUS_OK) && (phase_in != dsaraw_pkg::PHASE_DONE)) begin
         final_status = dsaraw_pkg::STATUS_TRUNCATED;
      end
      load_data.status = final_status;
      if (final_status == dsaraw_pkg::STATUS_OK) begin
         load_data.raw   = raw_in;
         load_data.count = {dsaraw_pkg::COUNT_W'(size)} << 1;
      end else begin
         load_data.raw   = '0;
         load_data.count = dsaraw_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && in_last)) begin
         phase_ff    <= dsaraw_pkg::PHASE_SEQ_TAG;
         second_ff   <= 1'b0;
         left_ff     <= '0;
         skip_ff     <= 1'b1;
         err_ff      <= dsaraw_pkg::STATUS_OK;
         tag_bad_ff  <= 1'b0;
         oversize_ff <= 1'b0;
         raw_ff      <= '0;
      end else if (take) begin
         phase_ff    <= phase_in;
         second_ff   <= second_in;
         left_ff     <= left_in;
         skip_ff     <= skip_in;
         err_ff      <= err_in;
         tag_bad_ff  <= tag_bad_in;
         oversize_ff <= oversize_in;
         raw_ff      <= raw_in;
      end
   end

endmodule

### rtl/core/dsaraw_emit.sv
`include "der_dsa_signature_to_raw_top_macros.svh"

module dsaraw_emit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  dsaraw_pkg::emit_load_type    load_data,
   dsaraw_rsp_if.source                 rsp,
   output logic                         can_load
);

   dsaraw_pkg::raw_type                 raw_ff;
   logic [dsaraw_pkg::COUNT_W-1:0]      count_ff;
   dsaraw_pkg::status_type              status_ff;
   logic                                fire;

   assign fire     = rsp.valid && rsp.ready;
   assign can_load = (count_ff == '0) ||
                     (fire && (count_ff == dsaraw_pkg::COUNT_W'(1)));

   assign rsp.valid    = (count_ff != '0);
   assign rsp.out_byte = raw_ff[0];
   assign rsp.out_last = (count_ff == dsaraw_pkg::COUNT_W'(1));
   assign rsp.status   = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= load_data.count;
      end else if (fire) begin
         count_ff <= count_ff - dsaraw_pkg::COUNT_W'(1);
      end
   end

   // payload, next byte always at slot zero
   always_ff @(posedge clock) begin
      if (load) begin
         raw_ff    <= load_data.raw;
         status_ff <= load_data.status;
      end else if (fire) begin
         raw_ff    <= raw_ff >> 8;
      end
   end

   `DSARAW_ASSERT_NOW(a_load_when_free, clock, reset, load, can_load)
   `DSARAW_ASSERT_NOW(a_error_single, clock, reset,
      rsp.valid && (status_ff != dsaraw_pkg::STATUS_OK),
      (rsp.out_byte == 8'd0) && rsp.out_last)
   `DSARAW_ASSERT_NEXT(a_burst_continues, clock, reset,
      fire && !rsp.out_last, rsp.valid)
   `DSARAW_ASSERT_NEXT(a_hold_on_stall, clock, reset,
      rsp.valid && !rsp.ready && !load, rsp.valid && $stable(count_ff))

endmodule

### rtl/core/der_dsa_signature_to_raw_top.sv
// DER signature to raw r||s converter. One DER byte is taken per cycle on req_if
// while it is ready, with in_last on the final byte. After the final byte the block
// delivers 2*int_size raw bytes (r then s, big-endian, one per cycle on rsp_if while
// it is ready) or a single error transaction with a nonzero status. Parsing of the
// next signature goes on while a burst drains; only its final byte waits until the
// single emission register has delivered the last transaction of the previous burst.
// int_size is written through csr_write_enable/csr_write_data only while the block is
// idle (the user's duty; the block does not enforce it). 0 acts as 1, above 32 as 32.
module der_dsa_signature_to_raw_top (
   input  logic                               clock,
   input  logic                               reset,
   dsaraw_req_if.sink                         req_if,
   dsaraw_rsp_if.source                       rsp_if,
   input  logic                               csr_write_enable,
   input  logic [dsaraw_pkg::SIZE_W-1:0]      csr_write_data
);

   logic [dsaraw_pkg::SIZE_W-1:0]   int_size_ff;
   logic                            take;
   logic                            load;
   logic                            can_load;
   dsaraw_pkg::emit_load_type       load_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         int_size_ff <= dsaraw_pkg::SIZE_W'(20);
      end else if (csr_write_enable) begin
         int_size_ff <= csr_write_data;
      end
   end

   assign req_if.ready = can_load || !req_if.in_last;
   assign take         = req_if.valid && req_if.ready;
   assign load         = take && req_if.in_last;

   dsaraw_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .int_size  (int_size_ff),
      .take      (take),
      .in_byte   (req_if.in_byte),
      .in_last   (req_if.in_last),
      .load_data (load_data)
   );

   dsaraw_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_data (load_data),
      .rsp       (rsp_if),
      .can_load  (can_load)
   );

endmodule
